FILE: hdl/srct_pkg.sv
`default_nettype none

package srct_pkg;

    // table geometry defaults
    localparam int ENTRY_COUNT_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 32;

    // field widths
    localparam int REQ_TYPE_W = 2;
    localparam int INDEX_W    = 10;
    localparam int FIELD_W    = 32;
    localparam int ACTIVE_W   = 11;
    localparam int PRATE_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int QBITS      = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_ALPHA    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_BETA     = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 11'd1024;
    localparam logic [PRATE_W-1:0]  PRATE_RST  = 16'd655;
    localparam logic [31:0]         ALPHA_RST  = 32'd65536;
    localparam logic [31:0]         BETA_RST   = 32'd6488064;

    // request codes; the unused code behaves as a query
    localparam logic [REQ_TYPE_W-1:0] REQ_IMPRESSION = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLICK      = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY      = 2'd2;

    localparam logic [FIELD_W-1:0] QUALITY_ONE = 32'h0001_0000;

    // divisor width for the default count width
    localparam int DEN_W_DEF = COUNT_BITS_DEF + FRAC_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV_RATE,
        ST_QUAL_LOAD,
        ST_DIV_QUAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic clear;
        logic update;
        logic load_rate;
        logic store_rate;
        logic load_qual;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic accepted;
        logic clear_last;
        logic idx_ok;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/srct_req_if.sv
`default_nettype none

interface srct_req_if;
    import srct_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INDEX_W-1:0]    entry_index;

    modport source (output valid, output req_type, output entry_index, input ready);
    modport sink   (input valid, input req_type, input entry_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/srct_res_if.sv
`default_nettype none

interface srct_res_if;
    import srct_pkg::*;

    logic               valid;
    logic               ready;
    logic               index_valid;
    logic [FIELD_W-1:0] impression_count;
    logic [FIELD_W-1:0] click_count;
    logic [FIELD_W-1:0] smoothed_rate;
    logic [FIELD_W-1:0] rate_lift;

    modport source (
        output valid, output index_valid, output impression_count,
        output click_count, output smoothed_rate, output rate_lift,
        input ready
    );
    modport sink (
        input valid, input index_valid, input impression_count,
        input click_count, input smoothed_rate, input rate_lift,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/smoothed_rate_counter_table_unit.sv
// channel   dir  payload                                                   role
// i_req     in   req_type, entry_index                                     event per entry
// o_res     out  index_valid, impression_count, click_count,               counts and ratios
//                smoothed_rate, rate_lift
// i_cfg_*   in   i_cfg_we, i_cfg_index, i_cfg_data                         register writes
//
// after reset a clearing sweep zeroes all ENTRY_COUNT rows, one a cycle (1024 by default);
// no transfer is taken on i_req until it ends
// an in-range result is registered after the table update and two divisions on the shared
// radix-2 divider, 32 quotient steps for the rate and 32 for the quality; an out-of-range
// result skips the divisions; a new transfer is taken only once the last result is loaded
// a stalled o_res holds its result; the block waits in its last step until the register frees

`default_nettype none

module smoothed_rate_counter_table_unit #(
    parameter int ENTRY_COUNT = srct_pkg::ENTRY_COUNT_DEF,
    parameter int COUNT_BITS  = srct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    srct_req_if.sink                              i_req,
    srct_res_if.source                            o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [srct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [srct_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import srct_pkg::*;

    t_cmd    cmd;
    t_status status;

    srct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    srct_dp #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );
endmodule

`default_nettype wire

FILE: hdl/srct_ram.sv
`default_nettype none

module srct_ram #(
    parameter int WIDTH = 2 * srct_pkg::COUNT_BITS_DEF,
    parameter int DEPTH = srct_pkg::ENTRY_COUNT_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: hdl/srct_div.sv
`default_nettype none

module srct_div #(
    parameter int DEN_W = srct_pkg::DEN_W_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [DEN_W-1:0]            i_rem0,
    input  wire logic [srct_pkg::QBITS-1:0]  i_lo,
    input  wire logic [DEN_W-1:0]            i_den,
    output logic                             o_done,
    output logic      [srct_pkg::QBITS-1:0]  o_quot
);
    import srct_pkg::*;

    localparam int CNT_W = $clog2(QBITS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QBITS-1:0] r_lo;
    logic             r_sat;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    // dividend bits shift out of r_lo as quotient bits shift in
    assign rem_sh = {r_rem, r_lo[QBITS-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QBITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_lo  <= i_lo;
            r_den <= i_den;
            // quotient of 2^32 or more when the upper dividend reaches the divisor
            r_sat <= i_rem0 >= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_lo  <= {r_lo[QBITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_lo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");
endmodule

`default_nettype wire

FILE: hdl/srct_ctrl.sv
`default_nettype none

module srct_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire srct_pkg::t_status i_status,
    output srct_pkg::t_cmd         o_cmd
);
    import srct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.accepted) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_status.idx_ok ? ST_LOAD : ST_DONE;
            end
            ST_LOAD: begin
                n_state = ST_DIV_RATE;
            end
            ST_DIV_RATE: begin
                if (i_status.div_done) n_state = ST_QUAL_LOAD;
            end
            ST_QUAL_LOAD: begin
                n_state = ST_DIV_QUAL;
            end
            ST_DIV_QUAL: begin
                if (i_status.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR:     o_cmd.clear      = 1'b1;
            ST_IDLE:      o_cmd.take       = 1'b1;
            ST_UPDATE:    o_cmd.update     = i_status.idx_ok;
            ST_LOAD:      o_cmd.load_rate  = 1'b1;
            ST_DIV_RATE:  o_cmd.store_rate = i_status.div_done;
            ST_QUAL_LOAD: o_cmd.load_qual  = 1'b1;
            ST_DIV_QUAL:  o_cmd = '0;
            ST_DONE:      o_cmd.out_load   = i_status.out_free;
            default:      o_cmd = '0;
        endcase
    end
endmodule

`default_nettype wire

FILE: hdl/srct_dp.sv
`default_nettype none

module srct_dp #(
    parameter int ENTRY_COUNT = srct_pkg::ENTRY_COUNT_DEF,
    parameter int COUNT_BITS  = srct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    srct_req_if.sink                              i_req,
    srct_res_if.source                            o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [srct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [srct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire srct_pkg::t_cmd                   i_cmd,
    output srct_pkg::t_status                     o_status
);
    import srct_pkg::*;

    localparam int ADDR_W = $clog2(ENTRY_COUNT);
    localparam int SUM_W  = (COUNT_BITS + FRAC_W > 33) ? COUNT_BITS + FRAC_W : 33;
    localparam int DEN_W  = SUM_W + 1;

    // configuration registers
    logic [ACTIVE_W-1:0] r_active;
    logic [PRATE_W-1:0]  r_prior_rate;
    logic [31:0]         r_alpha;
    logic [31:0]         r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= ACTIVE_RST;
            r_prior_rate <= PRATE_RST;
            r_alpha      <= ALPHA_RST;
            r_beta       <= BETA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_ENTRIES: r_active     <= i_cfg_data[ACTIVE_W-1:0];
                CFG_PRIOR_RATE:     r_prior_rate <= i_cfg_data[PRATE_W-1:0];
                CFG_PRIOR_ALPHA:    r_alpha      <= i_cfg_data;
                CFG_PRIOR_BETA:     r_beta       <= i_cfg_data;
                default:            r_alpha      <= r_alpha;
            endcase
        end
    end

    // request capture
    logic                  accepted;
    logic                  idx_ok_in;
    logic [REQ_TYPE_W-1:0] r_req;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_ok;

    assign i_req.ready = i_cmd.take;
    assign accepted    = i_req.valid & i_cmd.take;
    assign idx_ok_in   = ({1'b0, i_req.entry_index} < r_active)
                       && (32'(i_req.entry_index) < 32'(ENTRY_COUNT));

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_req  <= i_req.req_type;
            r_addr <= ADDR_W'(i_req.entry_index);
            r_ok   <= idx_ok_in;
        end
    end

    // clearing sweep after reset
    logic [ADDR_W-1:0] r_clr_addr;
    logic              clear_last;

    assign clear_last = r_clr_addr == ADDR_W'(ENTRY_COUNT - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // counter table, clicks in the upper half
    logic [2*COUNT_BITS-1:0] ram_rdata;
    logic [2*COUNT_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]       ram_waddr;
    logic                    ram_we;
    logic [COUNT_BITS-1:0]   cur_imps;
    logic [COUNT_BITS-1:0]   cur_clks;
    logic [COUNT_BITS-1:0]   n_imps;
    logic [COUNT_BITS-1:0]   n_clks;
    logic [COUNT_BITS-1:0]   r_imps;
    logic [COUNT_BITS-1:0]   r_clks;

    assign cur_imps = ram_rdata[COUNT_BITS-1:0];
    assign cur_clks = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];

    // counters stick at all ones
    assign n_imps = (r_req == REQ_IMPRESSION && cur_imps != '1)
                  ? cur_imps + COUNT_BITS'(1) : cur_imps;
    assign n_clks = (r_req == REQ_CLICK && cur_clks != '1)
                  ? cur_clks + COUNT_BITS'(1) : cur_clks;

    assign ram_we    = i_cmd.clear | i_cmd.update;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clear ? '0 : {n_clks, n_imps};

    srct_ram #(
        .WIDTH (2 * COUNT_BITS),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accepted),
        .i_raddr (ADDR_W'(i_req.entry_index)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_imps <= n_imps;
            r_clks <= n_clks;
        end
    end

    // shared divider: rate first, then quality from the stored rate
    logic [DEN_W-1:0] rate_rem0;
    logic [DEN_W-1:0] rate_den;
    logic [DEN_W-1:0] div_rem0;
    logic [QBITS-1:0] div_lo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [QBITS-1:0] div_quot;
    logic             r_den_zero;
    logic [QBITS-1:0] r_rate;

    // numerator (clicks*2^16 + alpha)*2^16 split at bit 32
    assign rate_rem0 = DEN_W'(r_clks) + DEN_W'(r_alpha[31:16]);
    assign rate_den  = DEN_W'({r_imps, {FRAC_W{1'b0}}}) + DEN_W'(r_alpha)
                     + DEN_W'(r_beta);

    always_comb begin
        if (i_cmd.load_qual) begin
            div_rem0 = DEN_W'(r_rate[31:16]);
            div_lo   = {r_rate[15:0], {FRAC_W{1'b0}}};
            div_den  = DEN_W'(r_prior_rate);
        end else begin
            div_rem0 = rate_rem0;
            div_lo   = {r_alpha[15:0], {FRAC_W{1'b0}}};
            div_den  = rate_den;
        end
    end

    srct_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_rate | i_cmd.load_qual),
        .i_rem0  (div_rem0),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rate) begin
            r_den_zero <= rate_den == '0;
        end
        if (i_cmd.store_rate) begin
            r_rate <= r_den_zero ? '0 : div_quot;
        end
    end

    // counts narrowed to the field width
    logic [FIELD_W-1:0] imps32;
    logic [FIELD_W-1:0] clks32;

    generate
        if (COUNT_BITS > FIELD_W) begin : g_wide
            assign imps32 = (|r_imps[COUNT_BITS-1:FIELD_W]) ? '1 : r_imps[FIELD_W-1:0];
            assign clks32 = (|r_clks[COUNT_BITS-1:FIELD_W]) ? '1 : r_clks[FIELD_W-1:0];
        end else begin : g_narrow
            assign imps32 = FIELD_W'(r_imps);
            assign clks32 = FIELD_W'(r_clks);
        end
    endgenerate

    // output register
    logic               r_out_valid;
    logic               r_out_ok;
    logic [FIELD_W-1:0] r_out_imps;
    logic [FIELD_W-1:0] r_out_clks;
    logic [FIELD_W-1:0] r_out_rate;
    logic [FIELD_W-1:0] r_out_qual;
    logic               out_free;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ok <= r_ok;
            if (r_ok) begin
                r_out_imps <= imps32;
                r_out_clks <= clks32;
                r_out_rate <= r_rate;
                r_out_qual <= div_quot;
            end else begin
                // index out of range: prior rate and unit quality
                r_out_imps <= '0;
                r_out_clks <= '0;
                r_out_rate <= FIELD_W'(r_prior_rate);
                r_out_qual <= QUALITY_ONE;
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.index_valid      = r_out_ok;
    assign o_res.impression_count = r_out_imps;
    assign o_res.click_count      = r_out_clks;
    assign o_res.smoothed_rate    = r_out_rate;
    assign o_res.rate_lift        = r_out_qual;

    always_comb begin
        o_status            = '0;
        o_status.accepted   = accepted;
        o_status.clear_last = clear_last;
        o_status.idx_ok     = r_ok;
        o_status.div_done   = div_done;
        o_status.out_free   = out_free;
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || o_res.ready)
        else $error("pending result overwritten");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !accepted && !i_cmd.update)
        else $error("table access during clearing sweep");
endmodule

`default_nettype wire

FILE: tb/smoothed_rate_counter_table_unit_tb.sv
module smoothed_rate_counter_table_unit_tb;
    import srct_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 800_000;
    localparam int TAIL_CYCLES     = 100;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 225;

    typedef struct packed {
        logic               index_valid;
        logic [FIELD_W-1:0] impression_count;
        logic [FIELD_W-1:0] click_count;
        logic [FIELD_W-1:0] smoothed_rate;
        logic [FIELD_W-1:0] rate_lift;
    } rate_result_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [REQ_TYPE_W-1:0] kind;
        logic [INDEX_W-1:0]    idx;
        bit                    typed;
        rate_result_t          want;
    } plan_row_t;

    localparam rate_result_t NO_CHECK    = '0;
    localparam rate_result_t OUT_OF_TBL  = '{1'b0, 32'd0, 32'd0, 32'd655, QUALITY_ONE};

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srct_req_if req_ch();
    srct_res_if res_ch();

    smoothed_rate_counter_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // own copy of the table and registers
    logic [31:0]         model_imps   [1024] = '{default: '0};
    logic [31:0]         model_clicks [1024] = '{default: '0};
    logic [ACTIVE_W-1:0] model_active     = ACTIVE_RST;
    logic [PRATE_W-1:0]  model_prior_rate = PRATE_RST;
    logic [31:0]         model_alpha      = ALPHA_RST;
    logic [31:0]         model_beta       = BETA_RST;

    rate_result_t pending_results[$];
    bit steady = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int invalid_seen = 0;
    int saturated_seen = 0;
    int settings_written = 0;
    int cycle_count = 0;

    plan_row_t directed_plan [29] = '{
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd0, 1'b1,
          '{1'b1, 32'd0, 32'd0, 32'd655, QUALITY_ONE}},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_IMPRESSION, 10'd1023, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_CLICK, 10'd1023, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_UNUSED, 10'd1023, 1'b0, NO_CHECK},
        '{1'b1, CFG_ACTIVE_ENTRIES, 32'd1000, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd1023, 1'b1, OUT_OF_TBL},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_CLICK, 10'd1000, 1'b1, OUT_OF_TBL},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd999, 1'b0, NO_CHECK},
        '{1'b1, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_IMPRESSION, 10'd0, 1'b1, OUT_OF_TBL},
        '{1'b1, CFG_ACTIVE_ENTRIES, 32'd2047, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd1023, 1'b0, NO_CHECK},
        // no prior at all: zero denominator on an untouched entry
        '{1'b1, CFG_PRIOR_ALPHA, 32'd0, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b1, CFG_PRIOR_BETA, 32'd0, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd5, 1'b1,
          '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0}},
        '{1'b1, CFG_PRIOR_RATE, 32'd0, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd5, 1'b1,
          '{1'b1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_CLICK, 10'd5, 1'b1,
          '{1'b1, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF}},
        // tiny alpha with clicks and no impressions drives the rate into saturation
        '{1'b1, CFG_PRIOR_ALPHA, 32'd1, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_CLICK, 10'd5, 1'b1,
          '{1'b1, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{1'b1, CFG_PRIOR_RATE, 32'd65535, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_IMPRESSION, 10'd5, 1'b0, NO_CHECK},
        '{1'b1, CFG_PRIOR_ALPHA, 32'hFFFF_FFFF, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b1, CFG_PRIOR_BETA, 32'hFFFF_FFFF, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_IMPRESSION, 10'd6, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd5, 1'b0, NO_CHECK},
        '{1'b1, CFG_ACTIVE_ENTRIES, 32'd3, REQ_QUERY, 10'd0, 1'b0, NO_CHECK},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_QUERY, 10'd1023, 1'b1,
          '{1'b0, 32'd0, 32'd0, 32'd65535, QUALITY_ONE}},
        '{1'b0, CFG_ACTIVE_ENTRIES, 32'd0, REQ_IMPRESSION, 10'd2, 1'b0, NO_CHECK}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic rate_result_t predict_entry_update(logic [REQ_TYPE_W-1:0] kind,
                                                          logic [INDEX_W-1:0] idx);
        rate_result_t r;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quot;
        logic [47:0]  qual_wide;
        r = '0;
        if (idx >= model_active || idx >= ENTRY_COUNT_DEF) begin
            r.smoothed_rate = {16'd0, model_prior_rate};
            r.rate_lift     = QUALITY_ONE;
            return r;
        end
        if (kind == REQ_IMPRESSION && model_imps[idx] != '1)
            model_imps[idx] = model_imps[idx] + 32'd1;
        else if (kind == REQ_CLICK && model_clicks[idx] != '1)
            model_clicks[idx] = model_clicks[idx] + 32'd1;
        r.index_valid      = 1'b1;
        r.impression_count = model_imps[idx];
        r.click_count      = model_clicks[idx];
        num = (({96'd0, model_clicks[idx]} << 16) + model_alpha) << 16;
        den = ({96'd0, model_imps[idx]} << 16) + model_alpha + model_beta;
        if (den == '0) begin
            r.smoothed_rate = '0;
        end else begin
            quot = num / den;
            r.smoothed_rate = (quot > 128'hFFFF_FFFF) ? '1 : quot[31:0];
        end
        if (model_prior_rate == '0) begin
            r.rate_lift = '1;
        end else begin
            qual_wide = {r.smoothed_rate, 16'd0} / model_prior_rate;
            r.rate_lift = (qual_wide[47:32] != '0) ? '1 : qual_wide[31:0];
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge i_clk);
        case (sel)
            CFG_ACTIVE_ENTRIES: model_active     = value[ACTIVE_W-1:0];
            CFG_PRIOR_RATE:     model_prior_rate = value[PRATE_W-1:0];
            CFG_PRIOR_ALPHA:    model_alpha      = value;
            CFG_PRIOR_BETA:     model_beta       = value;
            default: ;
        endcase
        settings_written++;
    endtask

    // always waits for a clock edge so valid is never lowered and raised again without an edge between
    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        cfg_we       <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic send_item(logic [REQ_TYPE_W-1:0] kind, logic [INDEX_W-1:0] idx,
                             bit typed, rate_result_t want);
        int gap;
        rate_result_t predicted;
        gap = steady ? 0 : $urandom_range(0, 8);
        cfg_we <= 1'b0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_index <= idx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = predict_entry_update(kind, idx);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%08h got 0x%08h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    initial begin : result_sink
        int stall;
        rate_result_t want;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            results_seen++;
            if (res_ch.index_valid !== 1'b1)
                invalid_seen++;
            if (res_ch.smoothed_rate === '1)
                saturated_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with no item outstanding", $time);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("index_valid", {31'd0, want.index_valid},
                              {31'd0, res_ch.index_valid});
                compare_field("impression_count", want.impression_count,
                              res_ch.impression_count);
                compare_field("click_count", want.click_count, res_ch.click_count);
                compare_field("smoothed_rate", want.smoothed_rate, res_ch.smoothed_rate);
                compare_field("rate_lift", want.rate_lift, res_ch.rate_lift);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int pick;
        int span;
        logic [REQ_TYPE_W-1:0] kind;
        logic [INDEX_W-1:0]    idx;
        logic [INDEX_W-1:0]    hot_entries [8];
        logic [CFG_DATA_W-1:0] set_active, set_rate, set_alpha, set_beta;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_ACTIVE_ENTRIES;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_QUERY;
        req_ch.entry_index <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            if (directed_plan[r].is_write) begin
                wait_results_drained();
                write_reg(directed_plan[r].reg_sel, directed_plan[r].value);
            end else begin
                send_item(directed_plan[r].kind, directed_plan[r].idx,
                          directed_plan[r].typed, directed_plan[r].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_results_drained();
            steady = (phase == 2 || phase == 5);
            case (phase)
                0: begin
                    set_active = ACTIVE_RST;
                    set_rate   = PRATE_RST;
                    set_alpha  = ALPHA_RST;
                    set_beta   = BETA_RST;
                end
                1: begin
                    set_active = $urandom_range(1, 1024);
                    set_rate   = $urandom_range(1, 65535);
                    set_alpha  = $urandom_range(0, 1 << 20);
                    set_beta   = $urandom_range(0, 1 << 24);
                end
                2: begin
                    set_active = 32'd2047;
                    set_rate   = 32'd1;
                    set_alpha  = '0;
                    set_beta   = $urandom_range(1 << 16, 1 << 20);
                end
                3: begin
                    set_active = $urandom_range(1, 32);
                    set_rate   = 32'd65535;
                    set_alpha  = '1;
                    set_beta   = '1;
                end
                4: begin
                    set_active = $urandom_range(0, 2047);
                    set_rate   = {16'd0, 16'($urandom)};
                    set_alpha  = $urandom;
                    set_beta   = $urandom;
                end
                default: begin
                    // no beta: entries with clicks but no impressions can saturate the rate
                    set_active = 32'd1024;
                    set_rate   = $urandom_range(1, 65535);
                    set_alpha  = $urandom_range(0, 65535);
                    set_beta   = '0;
                end
            endcase
            write_reg(CFG_ACTIVE_ENTRIES, set_active);
            write_reg(CFG_PRIOR_RATE, set_rate);
            write_reg(CFG_PRIOR_ALPHA, set_alpha);
            write_reg(CFG_PRIOR_BETA, set_beta);

            // a few busy entries so counts build up past the prior
            span = (model_active == 0 || model_active > 1024) ? 1024 : int'(model_active);
            foreach (hot_entries[k])
                hot_entries[k] = INDEX_W'($urandom_range(0, span - 1));

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 59) == 0)
                    wait_results_drained();
                pick = $urandom_range(0, 19);
                kind = (pick < 10) ? REQ_IMPRESSION :
                       (pick < 15) ? REQ_CLICK :
                       (pick < 19) ? REQ_QUERY : REQ_UNUSED;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    idx = hot_entries[$urandom_range(0, 7)];
                else if (pick < 88)
                    idx = INDEX_W'($urandom);
                else
                    idx = INDEX_W'(model_active - 11'd1 + 11'($urandom_range(0, 2)));
                send_item(kind, idx, 1'b0, NO_CHECK);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches += pending_results.size();
        end
        $display("covered %0d transfers in, %0d out, %0d register writes", items_sent,
                 results_seen, settings_written);
        $display("out-of-range results %0d, saturated rates %0d, mismatches %0d",
                 invalid_seen, saturated_seen, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
